// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOOQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sooq_pkg.sv
package sooq_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_ARRIVE  = 2'd0;
  localparam logic [1:0] MODE_OLDEST  = 2'd1;
  localparam logic [1:0] MODE_LARGEST = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_SERVED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_OLDEST,
    OP_LARGEST,
    OP_REJECT
  } op_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FIND,
    B_SCAN,
    B_LAST,
    B_TAKE,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ticket;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [31:0] ticket;
    logic [31:0] amount;
  } slot_t;

endpackage

// File: rtl/core/sooq_front.sv
module sooq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sooq_pkg::in_item_t in_item_i,
  output logic               cmd_valid_o,
  output sooq_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned QPTR_W = (sooq_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(sooq_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(sooq_pkg::QUEUE_DEPTH + 1);

  sooq_pkg::cmd_t q_mem [sooq_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  sooq_pkg::cmd_t    cmd;
  logic              push;
  logic              pop;

  always_comb begin
    cmd.amount = in_item_i.amount;
    unique case (in_item_i.mode)
      sooq_pkg::MODE_ARRIVE:  cmd.op = sooq_pkg::OP_ARRIVE;
      sooq_pkg::MODE_OLDEST:  cmd.op = sooq_pkg::OP_OLDEST;
      sooq_pkg::MODE_LARGEST: cmd.op = sooq_pkg::OP_LARGEST;
      default:                cmd.op = sooq_pkg::OP_REJECT;
    endcase
  end

  assign in_stall_o  = (cnt_q == QCNT_W'(sooq_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(sooq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(sooq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                    rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd;
    end
  end

endmodule

// File: rtl/core/sooq_back.sv
module sooq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  sooq_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sooq_pkg::out_item_t out_item_o
);

  localparam int unsigned SW = sooq_pkg::SLOT_W;
  localparam int unsigned CW = sooq_pkg::CNT_W;

  sooq_pkg::slot_t mem [sooq_pkg::CAPACITY];

  sooq_pkg::back_state_e state_q;
  sooq_pkg::back_state_e state_d;

  logic [sooq_pkg::CAPACITY-1:0] valid_q;
  logic [CW-1:0]                 count_q;
  logic [31:0]                   next_ticket_q;
  sooq_pkg::op_e                 op_q;
  logic [31:0]                   amount_q;
  logic [SW-1:0]                 idx_q;
  logic                          rd_pend_q;
  logic                          rd_live_q;
  logic [SW-1:0]                 rd_idx_q;
  sooq_pkg::slot_t               rd_data_q;
  logic                          best_found_q;
  logic [SW-1:0]                 best_idx_q;
  logic [31:0]                   best_tkt_q;
  logic [31:0]                   best_amt_q;
  sooq_pkg::out_item_t           res_q;
  logic                          out_valid_q;
  sooq_pkg::out_item_t           out_q;

  logic slot_live;
  logic idx_last;
  logic arrive_ok;
  logic is_serve;
  logic out_free;
  logic better;
  logic mem_we;
  logic rd_issue;
  logic load_out;

  assign slot_live = valid_q[idx_q];
  assign idx_last  = (idx_q == SW'(sooq_pkg::CAPACITY - 1));
  assign arrive_ok = (count_q != CW'(sooq_pkg::CAPACITY)) && (next_ticket_q != '0);
  assign is_serve  = (cmd_i.op == sooq_pkg::OP_OLDEST) || (cmd_i.op == sooq_pkg::OP_LARGEST);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (!best_found_q) begin
      better = 1'b1;
    end else if (op_q == sooq_pkg::OP_LARGEST) begin
      better = (rd_data_q.amount > best_amt_q) ||
               ((rd_data_q.amount == best_amt_q) && (rd_data_q.ticket < best_tkt_q));
    end else begin
      better = (rd_data_q.ticket < best_tkt_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sooq_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            sooq_pkg::OP_ARRIVE: state_d = arrive_ok ? sooq_pkg::B_FIND : sooq_pkg::B_DONE;
            sooq_pkg::OP_OLDEST,
            sooq_pkg::OP_LARGEST: begin
              state_d = (count_q == '0) ? sooq_pkg::B_DONE : sooq_pkg::B_SCAN;
            end
            default: state_d = sooq_pkg::B_DONE;
          endcase
        end
      end
      sooq_pkg::B_FIND: begin
        if (!slot_live) begin
          state_d = sooq_pkg::B_DONE;
        end
      end
      sooq_pkg::B_SCAN: begin
        if (idx_last) begin
          state_d = sooq_pkg::B_LAST;
        end
      end
      sooq_pkg::B_LAST: state_d = sooq_pkg::B_TAKE;
      sooq_pkg::B_TAKE: state_d = sooq_pkg::B_DONE;
      sooq_pkg::B_DONE: begin
        if (out_free) begin
          state_d = sooq_pkg::B_IDLE;
        end
      end
      default: state_d = sooq_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = (state_q == sooq_pkg::B_IDLE);
    mem_we    = (state_q == sooq_pkg::B_FIND) && !slot_live;
    rd_issue  = (state_q == sooq_pkg::B_SCAN);
    load_out  = (state_q == sooq_pkg::B_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sooq_pkg::B_IDLE;
      valid_q       <= '0;
      count_q       <= '0;
      next_ticket_q <= 32'd1;
      op_q          <= sooq_pkg::OP_REJECT;
      amount_q      <= '0;
      idx_q         <= '0;
      rd_pend_q     <= 1'b0;
      rd_live_q     <= 1'b0;
      rd_idx_q      <= '0;
      best_found_q  <= 1'b0;
      best_idx_q    <= '0;
      best_tkt_q    <= '0;
      best_amt_q    <= '0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_issue;
      rd_live_q <= slot_live;
      rd_idx_q  <= idx_q;

      if (rd_pend_q && rd_live_q && better) begin
        best_found_q <= 1'b1;
        best_idx_q   <= rd_idx_q;
        best_tkt_q   <= rd_data_q.ticket;
        best_amt_q   <= rd_data_q.amount;
      end

      unique case (state_q)
        sooq_pkg::B_IDLE: begin
          if (cmd_valid_i) begin
            op_q         <= cmd_i.op;
            amount_q     <= cmd_i.amount;
            idx_q        <= '0;
            best_found_q <= 1'b0;
            res_q.ticket <= '0;
            res_q.status <= is_serve ? sooq_pkg::ST_EMPTY : sooq_pkg::ST_FULL;
          end
        end
        sooq_pkg::B_FIND: begin
          if (slot_live) begin
            idx_q <= idx_q + SW'(1);
          end else begin
            valid_q[idx_q] <= 1'b1;
            count_q        <= count_q + CW'(1);
            res_q.status   <= sooq_pkg::ST_ACCEPTED;
            res_q.ticket   <= next_ticket_q;
            next_ticket_q  <= next_ticket_q + 32'd1;
          end
        end
        sooq_pkg::B_SCAN: begin
          idx_q <= idx_q + SW'(1);
        end
        sooq_pkg::B_TAKE: begin
          valid_q[best_idx_q] <= 1'b0;
          count_q             <= count_q - CW'(1);
          res_q.status        <= sooq_pkg::ST_SERVED;
          res_q.ticket        <= best_tkt_q;
        end
        default: begin
        end
      endcase

      if (load_out) begin
        out_valid_q <= 1'b1;
        out_q       <= res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= '{ticket: next_ticket_q, amount: amount_q};
    end
    rd_data_q <= mem[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/serve_oldest_or_richest_queue_top.sv
// Shared waiting store of CAPACITY entries served either oldest first or by
// largest amount, with ties going to the lower ticket. Each transaction on the
// input channel yields exactly one result transaction, in order. A front stage
// decodes the mode into a two-entry command queue, so up to two further
// transactions are taken while the back end is busy. An arrival looks for a
// free slot one valid bit per cycle. A serve reads every slot through the
// single read port of the slot memory, one slot per cycle. Serving an empty
// store, adding to a full store or once tickets run out, and an unknown mode
// go straight from the idle state to the done state. Tickets start at 1;
// after ticket 0xFFFFFFFF is issued every further arrival is refused, while
// serving continues.
module serve_oldest_or_richest_queue_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sooq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sooq_pkg::out_item_t out_item_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  sooq_pkg::cmd_t cmd;

  sooq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sooq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/sooq_checker.sv
`include "assert_macros.svh"

module sooq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sooq_pkg::out_item_t out_item_o
);

  `SOOQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i,
    out_valid_o && $stable(out_item_o),
    "Stalled result transaction changed.")

  `SOOQ_ASSERT_SAME(a_out_drop, clk_i, rst_ni,
    $fell(out_valid_o),
    $past(!out_stall_i),
    "Result transaction withdrawn without being taken.")

  `SOOQ_ASSERT_SAME(a_err_ticket, clk_i, rst_ni,
    out_valid_o && (out_item_o.status == sooq_pkg::ST_EMPTY ||
                    out_item_o.status == sooq_pkg::ST_FULL),
    out_item_o.ticket == 32'd0,
    "Refused transaction carries a ticket.")

  `SOOQ_ASSERT_SAME(a_acc_ticket, clk_i, rst_ni,
    out_valid_o && (out_item_o.status == sooq_pkg::ST_ACCEPTED ||
                    out_item_o.status == sooq_pkg::ST_SERVED),
    out_item_o.ticket != 32'd0,
    "Accepted or served transaction has ticket zero.")

endmodule

bind serve_oldest_or_richest_queue_top sooq_checker u_checker (.*);

// File: bench/serve_oldest_or_richest_queue_top_tb.sv
`timescale 1ns / 1ps

module serve_oldest_or_richest_queue_top_tb;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sooq_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  sooq_pkg::out_item_t out_item;

  logic        slot_used [sooq_pkg::CAPACITY];
  logic [31:0] slot_tkt [sooq_pkg::CAPACITY];
  logic [31:0] slot_amt [sooq_pkg::CAPACITY];
  logic [31:0] next_tkt;

  sooq_pkg::out_item_t awaited_results[$];
  sooq_pkg::out_item_t oldest_awaited;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_burst = 0;

  serve_oldest_or_richest_queue_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sooq_pkg::out_item_t store_predict(input sooq_pkg::in_item_t item);
    sooq_pkg::out_item_t res;
    int                  pick;
    res.status = sooq_pkg::ST_FULL;
    res.ticket = '0;
    pick = -1;
    case (item.mode)
      sooq_pkg::MODE_ARRIVE: begin
        for (int i = 0; i < sooq_pkg::CAPACITY; i++) begin
          if (pick < 0 && !slot_used[i]) pick = i;
        end
        if (pick >= 0 && next_tkt != 32'd0) begin
          slot_used[pick] = 1'b1;
          slot_tkt[pick] = next_tkt;
          slot_amt[pick] = item.amount;
          res.status = sooq_pkg::ST_ACCEPTED;
          res.ticket = next_tkt;
          next_tkt = next_tkt + 32'd1;
        end
      end
      sooq_pkg::MODE_OLDEST, sooq_pkg::MODE_LARGEST: begin
        for (int i = 0; i < sooq_pkg::CAPACITY; i++) begin
          if (slot_used[i]) begin
            if (pick < 0) begin
              pick = i;
            end else if (item.mode == sooq_pkg::MODE_LARGEST) begin
              if (slot_amt[i] > slot_amt[pick] ||
                  (slot_amt[i] == slot_amt[pick] && slot_tkt[i] < slot_tkt[pick]))
                pick = i;
            end else if (slot_tkt[i] < slot_tkt[pick]) begin
              pick = i;
            end
          end
        end
        if (pick < 0) begin
          res.status = sooq_pkg::ST_EMPTY;
        end else begin
          slot_used[pick] = 1'b0;
          res.status = sooq_pkg::ST_SERVED;
          res.ticket = slot_tkt[pick];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] pick_amount();
    logic [31:0] a;
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 7);
      1: a = $urandom;
      2: a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: a = {8'($urandom_range(0, 255)), 24'h0};
    endcase
    return a;
  endfunction

  task automatic offer_request(input logic [1:0] mode, input logic [31:0] amount);
    sooq_pkg::in_item_t  item;
    sooq_pkg::out_item_t predicted;
    item.mode = mode;
    item.amount = amount;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = store_predict(item);
    awaited_results = {awaited_results, predicted};
    @(negedge clk);
  endtask

  task automatic test_corner_cases();
    offer_request(sooq_pkg::MODE_OLDEST, 32'h0);
    offer_request(sooq_pkg::MODE_LARGEST, 32'hFFFF_FFFF);
    offer_request(MODE_UNKNOWN, 32'h1234_5678);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'h0000_0000);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'hFFFF_FFFF);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'hFFFF_FFFF);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'h5555_5555);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'hAAAA_AAAA);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'h0000_0000);
    offer_request(sooq_pkg::MODE_LARGEST, 32'h0);
    offer_request(sooq_pkg::MODE_LARGEST, 32'hFFFF_FFFF);
    offer_request(sooq_pkg::MODE_OLDEST, 32'h0);
    offer_request(MODE_UNKNOWN, 32'hFFFF_FFFF);
    offer_request(sooq_pkg::MODE_LARGEST, 32'h0);
    offer_request(sooq_pkg::MODE_ARRIVE, 32'h0000_0001);
    offer_request(sooq_pkg::MODE_OLDEST, 32'hFFFF_FFFF);
    offer_request(sooq_pkg::MODE_LARGEST, 32'h0);
    offer_request(sooq_pkg::MODE_LARGEST, 32'h0);
    offer_request(sooq_pkg::MODE_LARGEST, 32'h0);
    offer_request(sooq_pkg::MODE_OLDEST, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    repeat (sooq_pkg::CAPACITY + 3) offer_request(sooq_pkg::MODE_ARRIVE, pick_amount());
    repeat (sooq_pkg::CAPACITY / 2) begin
      offer_request($urandom_range(0, 1) ? sooq_pkg::MODE_OLDEST : sooq_pkg::MODE_LARGEST,
                    $urandom);
    end
    repeat (sooq_pkg::CAPACITY / 2 + 2) offer_request(sooq_pkg::MODE_ARRIVE, pick_amount());
    repeat (sooq_pkg::CAPACITY + 2) begin
      offer_request($urandom_range(0, 1) ? sooq_pkg::MODE_OLDEST : sooq_pkg::MODE_LARGEST,
                    $urandom);
    end
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (24) begin
      offer_request($urandom_range(0, 1) ? sooq_pkg::MODE_ARRIVE : sooq_pkg::MODE_LARGEST,
                    pick_amount());
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned arrive_pct;
    logic [1:0]  mode;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 2))
        0: arrive_pct = 20;
        1: arrive_pct = 50;
        default: arrive_pct = 80;
      endcase
      repeat ($urandom_range(20, 90)) begin
        if (sent < count) begin
          if ($urandom_range(0, 99) < 3) begin
            mode = MODE_UNKNOWN;
          end else if ($urandom_range(0, 99) < arrive_pct) begin
            mode = sooq_pkg::MODE_ARRIVE;
          end else begin
            mode = $urandom_range(0, 1) ? sooq_pkg::MODE_OLDEST : sooq_pkg::MODE_LARGEST;
          end
          offer_request(mode, pick_amount());
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (!idle_en) begin
      out_stall = 1'b0;
    end else if (stall_burst > 0) begin
      out_stall = 1'b1;
      stall_burst--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall = 1'b1;
      stall_burst = $urandom_range(0, 5);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual status %0d ticket %0d",
                 $time, out_item.status, out_item.ticket);
        mismatch_count++;
      end else begin
        oldest_awaited = awaited_results.pop_front();
        if (out_item.status !== oldest_awaited.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, oldest_awaited.status, out_item.status);
          mismatch_count++;
        end
        if (out_item.ticket !== oldest_awaited.ticket) begin
          $display("%0t: ticket mismatch: expected %0d, actual %0d",
                   $time, oldest_awaited.ticket, out_item.ticket);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    for (int i = 0; i < sooq_pkg::CAPACITY; i++) begin
      slot_used[i] = 1'b0;
      slot_tkt[i] = '0;
      slot_amt[i] = '0;
    end
    next_tkt = 32'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corner_cases();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_traffic(1000);
    idle_en = 1'b0;
    test_random_traffic(150);
    in_valid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sooq_pkg.sv
rtl/core/sooq_front.sv
rtl/core/sooq_back.sv
rtl/core/serve_oldest_or_richest_queue_top.sv
rtl/core/sooq_checker.sv
bench/serve_oldest_or_richest_queue_top_tb.sv
